>>> rtl/rvd_pkg.sv
// package with decode table, format codes and result type for the instruction decoder
package rvd_pkg;

	localparam int unsigned NumEntries = 126;
	localparam int unsigned IdxW = 7;
	localparam int unsigned AddrW = 64;
	localparam logic [11:0] NoKey = 12'hfff;

	typedef enum logic [2:0] {
		FMT_I  = 3'd0,
		FMT_S  = 3'd1,
		FMT_U  = 3'd2,
		FMT_UJ = 3'd3,
		FMT_SB = 3'd4,
		FMT_R  = 3'd5
	} fmt_t;

	typedef struct packed {
		logic [6:0]  opc;
		logic [2:0]  f3;
		fmt_t        fmt;
		logic [11:0] key;
		logic        keyed;
	} entry_t;

	typedef struct packed {
		logic             hit;
		logic [IdxW-1:0]  idx;
		fmt_t             fmt;
	} match_t;

	function automatic entry_t ent(input int o, input int f, input fmt_t k, input int key);
		entry_t e;
		e.opc = o[6:0];
		e.f3 = f[2:0];
		e.fmt = k;
		e.keyed = (key >= 0);
		e.key = (key >= 0) ? key[11:0] : NoKey;
		return e;
	endfunction

	function automatic entry_t table_entry(input int n);
		entry_t e;
		e = ent(0, 0, FMT_I, -1);
		unique case (n)
			0: e = ent(3,0,FMT_I,-1); 1: e = ent(3,1,FMT_I,-1); 2: e = ent(3,2,FMT_I,-1);
			3: e = ent(3,3,FMT_I,-1); 4: e = ent(3,4,FMT_I,-1); 5: e = ent(3,5,FMT_I,-1);
			6: e = ent(3,6,FMT_I,-1); 7: e = ent(3,7,FMT_I,-1);
			8: e = ent(15,0,FMT_I,-1); 9: e = ent(15,1,FMT_I,-1);
			10: e = ent(19,0,FMT_I,0); 11: e = ent(19,0,FMT_I,-1); 12: e = ent(19,1,FMT_R,0);
			13: e = ent(19,2,FMT_I,-1); 14: e = ent(19,3,FMT_I,-1); 15: e = ent(19,4,FMT_I,-1);
			16: e = ent(19,5,FMT_R,0); 17: e = ent(19,5,FMT_R,'h20);
			18: e = ent(19,6,FMT_I,-1); 19: e = ent(19,7,FMT_I,-1);
			20: e = ent(23,0,FMT_U,-1);
			21: e = ent(27,0,FMT_I,0); 22: e = ent(27,0,FMT_I,-1); 23: e = ent(27,1,FMT_R,0);
			24: e = ent(27,5,FMT_R,0); 25: e = ent(27,5,FMT_R,'h20);
			26: e = ent(35,0,FMT_S,-1); 27: e = ent(35,1,FMT_S,-1); 28: e = ent(35,2,FMT_S,-1);
			29: e = ent(35,3,FMT_S,-1); 30: e = ent(35,4,FMT_S,-1); 31: e = ent(35,5,FMT_S,-1);
			32: e = ent(35,6,FMT_S,-1); 33: e = ent(35,7,FMT_S,-1);
			34: e = ent(47,2,FMT_R,'h08); 35: e = ent(47,2,FMT_R,'h0c);
			36: e = ent(47,2,FMT_R,'h04); 37: e = ent(47,2,FMT_R,'h00);
			38: e = ent(47,2,FMT_R,'h10); 39: e = ent(47,2,FMT_R,'h30);
			40: e = ent(47,2,FMT_R,'h20); 41: e = ent(47,2,FMT_R,'h40);
			42: e = ent(47,2,FMT_R,'h50); 43: e = ent(47,2,FMT_R,'h60);
			44: e = ent(47,2,FMT_R,'h70);
			45: e = ent(47,2,FMT_R,'h08); 46: e = ent(47,2,FMT_R,'h0c);
			47: e = ent(47,2,FMT_R,'h06); 48: e = ent(47,2,FMT_R,'h02);
			49: e = ent(47,2,FMT_R,'h12); 50: e = ent(47,2,FMT_R,'h32);
			51: e = ent(47,2,FMT_R,'h22); 52: e = ent(47,2,FMT_R,'h42);
			53: e = ent(47,2,FMT_R,'h52); 54: e = ent(47,2,FMT_R,'h62);
			55: e = ent(47,2,FMT_R,'h72);
			56: e = ent(47,2,FMT_R,'h06); 57: e = ent(47,2,FMT_R,'h01);
			58: e = ent(47,2,FMT_R,'h11); 59: e = ent(47,2,FMT_R,'h31);
			60: e = ent(47,2,FMT_R,'h21); 61: e = ent(47,2,FMT_R,'h41);
			62: e = ent(47,2,FMT_R,'h51); 63: e = ent(47,2,FMT_R,'h61);
			64: e = ent(47,2,FMT_R,'h71);
			65: e = ent(47,3,FMT_R,'h04); 66: e = ent(47,3,FMT_R,'h00);
			67: e = ent(47,3,FMT_R,'h10); 68: e = ent(47,3,FMT_R,'h30);
			69: e = ent(47,3,FMT_R,'h20); 70: e = ent(47,3,FMT_R,'h40);
			71: e = ent(47,3,FMT_R,'h50); 72: e = ent(47,3,FMT_R,'h60);
			73: e = ent(47,3,FMT_R,'h70);
			74: e = ent(47,3,FMT_R,'h08); 75: e = ent(47,3,FMT_R,'h0c);
			76: e = ent(47,3,FMT_R,'h06); 77: e = ent(47,3,FMT_R,'h02);
			78: e = ent(47,3,FMT_R,'h12); 79: e = ent(47,3,FMT_R,'h32);
			80: e = ent(47,3,FMT_R,'h22); 81: e = ent(47,3,FMT_R,'h42);
			82: e = ent(47,3,FMT_R,'h52); 83: e = ent(47,3,FMT_R,'h62);
			84: e = ent(47,3,FMT_R,'h72);
			85: e = ent(47,3,FMT_R,'h06); 86: e = ent(47,3,FMT_R,'h01);
			87: e = ent(47,3,FMT_R,'h11); 88: e = ent(47,3,FMT_R,'h31);
			89: e = ent(47,3,FMT_R,'h21); 90: e = ent(47,3,FMT_R,'h41);
			91: e = ent(47,3,FMT_R,'h51); 92: e = ent(47,3,FMT_R,'h61);
			93: e = ent(47,3,FMT_R,'h71);
			94: e = ent(51,0,FMT_R,0); 95: e = ent(51,0,FMT_R,'h20); 96: e = ent(51,1,FMT_R,0);
			97: e = ent(51,2,FMT_R,0); 98: e = ent(51,3,FMT_R,0); 99: e = ent(51,4,FMT_R,0);
			100: e = ent(51,5,FMT_R,0); 101: e = ent(51,5,FMT_R,'h20);
			102: e = ent(51,6,FMT_R,0); 103: e = ent(51,7,FMT_R,0);
			104: e = ent(55,0,FMT_U,-1);
			105: e = ent(59,0,FMT_R,0); 106: e = ent(59,0,FMT_R,'h20); 107: e = ent(59,1,FMT_R,0);
			108: e = ent(59,5,FMT_R,0); 109: e = ent(59,5,FMT_R,'h20);
			110: e = ent(99,0,FMT_SB,-1); 111: e = ent(99,1,FMT_SB,-1);
			112: e = ent(99,4,FMT_SB,-1); 113: e = ent(99,5,FMT_SB,-1);
			114: e = ent(99,6,FMT_SB,-1); 115: e = ent(99,7,FMT_SB,-1);
			116: e = ent(103,0,FMT_I,-1); 117: e = ent(111,0,FMT_UJ,-1);
			118: e = ent(115,0,FMT_I,'h101); 119: e = ent(115,0,FMT_I,'h102);
			120: e = ent(115,2,FMT_I,'hc00); 121: e = ent(115,2,FMT_I,'hc80);
			122: e = ent(115,2,FMT_I,'hc01); 123: e = ent(115,2,FMT_I,'hc81);
			124: e = ent(115,2,FMT_I,'hc02); 125: e = ent(115,2,FMT_I,'hc82);
			default: e = ent(0, 0, FMT_I, -1);
		endcase
		return e;
	endfunction

endpackage

>>> rtl/riscv_instruction_decoder.sv
// top level of the instruction decoder: input register, decode logic, result register
// Decodes one RV64 instruction word per cycle, unless the output stalls, against a fixed
// 126-entry table; the first matching entry gives the mnemonic index, register fields and
// an immediate or branch/jump target. An accepted word is held in the input register and
// decoded combinationally from it, and its result is captured in the output register when
// that register is empty or being drained (two register stages), so throughput is one
// word per cycle while the output is not stalled; both registers advance together whenever
// the output register is empty or being drained, and a stalled output blocks the input
// only once the input register is also full.
module riscv_instruction_decoder import rvd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     instr_word,
	input  logic [63:0]     instr_address,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            matched,
	output logic [6:0]      mnemonic,
	output logic [4:0]      dest_reg,
	output logic [4:0]      src1_reg,
	output logic [4:0]      src2_reg,
	output logic [63:0]     operand_value
);

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [63:0] addr_s1;
	logic        adv;
	match_t      m;
	logic [4:0]  rd, rs1, rs2;
	logic [63:0] val;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= instr_word;
			addr_s1 <= instr_address;
		end
	end

	rvd_match u_match (
		.word   (word_s1),
		.result (m)
	);

	rvd_fields u_fields (
		.word    (word_s1),
		.address (addr_s1),
		.sel     (m),
		.rd      (rd),
		.rs1     (rs1),
		.rs2     (rs2),
		.value   (val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			matched <= m.hit;
			mnemonic <= m.idx;
			dest_reg <= rd;
			src1_reg <= rs1;
			src2_reg <= rs2;
			operand_value <= val;
		end
	end

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> mnemonic == '0 && operand_value == '0 && dest_reg == '0)
		else $error("unmatched result carries nonzero fields");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mnemonic) && $stable(operand_value))
		else $error("stalled result changed");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv |=> out_valid)
		else $error("decoded word lost");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input blocked with empty stage");

endmodule

>>> rtl/rvd_match.sv
// table match: compares one word against every entry and picks the first hit
module rvd_match import rvd_pkg::*; (
	input  logic [31:0] word,
	output match_t      result
);

	logic [NumEntries-1:0] hits;
	fmt_t                  fmts [NumEntries];

	for (genvar n = 0; n < NumEntries; n++) begin : g_ent
		localparam entry_t E = table_entry(n);
		logic f3_ok;
		assign f3_ok = (word[14:12] == E.f3);
		assign fmts[n] = E.fmt;
		always_comb begin
			hits[n] = 1'b0;
			if (word[6:0] == E.opc) begin
				unique case (E.fmt)
					FMT_U, FMT_UJ: hits[n] = 1'b1;
					FMT_I: hits[n] = f3_ok && (!E.keyed || word[31:20] == E.key);
					FMT_S, FMT_SB: hits[n] = f3_ok;
					FMT_R: hits[n] = f3_ok && (word[31:25] == E.key[6:0]);
					default: hits[n] = 1'b0;
				endcase
			end
		end
	end

	// lowest index wins
	always_comb begin
		result = '0;
		for (int n = NumEntries - 1; n >= 0; n--) begin
			if (hits[n]) begin
				result.hit = 1'b1;
				result.idx = IdxW'(n);
				result.fmt = fmts[n];
			end
		end
	end

endmodule

>>> rtl/rvd_fields.sv
// field extraction and immediate or target formation for the matched format
module rvd_fields import rvd_pkg::*; (
	input  logic [31:0]      word,
	input  logic [AddrW-1:0] address,
	input  match_t           sel,
	output logic [4:0]       rd,
	output logic [4:0]       rs1,
	output logic [4:0]       rs2,
	output logic [AddrW-1:0] value
);

	logic [AddrW-1:0] imm_i, imm_s, imm_b, imm_j;

	assign imm_i = {{(AddrW-12){word[31]}}, word[31:20]};
	assign imm_s = {{(AddrW-12){word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{(AddrW-13){word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
	assign imm_j = {{(AddrW-21){word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

	always_comb begin
		rd = '0;
		rs1 = '0;
		rs2 = '0;
		value = '0;
		if (sel.hit) begin
			unique case (sel.fmt)
				FMT_I: begin
					rd = word[11:7];
					rs1 = word[19:15];
					value = imm_i;
				end
				FMT_S: begin
					rs1 = word[19:15];
					rs2 = word[24:20];
					value = imm_s;
				end
				FMT_U: begin
					rd = word[11:7];
					value = {{(AddrW-20){1'b0}}, word[31:12]};
				end
				FMT_UJ: value = address + imm_j;
				FMT_SB: begin
					rs1 = word[19:15];
					rs2 = word[24:20];
					value = address + imm_b;
				end
				FMT_R: begin
					rd = word[11:7];
					rs1 = word[19:15];
					rs2 = word[24:20];
				end
				default: value = '0;
			endcase
		end
	end

endmodule
